// File: rtl/cau_pkg.sv
// Package with the types, codes and helper functions of the complex arithmetic unit.
`default_nettype none

package cau_pkg;

    // Default for the largest exponent that the power operation honors.
    localparam int MAX_EXPONENT_DEF = 31;

    // Operation codes.
    localparam logic [3:0] OP_ADD      = 4'd0;
    localparam logic [3:0] OP_SUB      = 4'd1;
    localparam logic [3:0] OP_MUL      = 4'd2;
    localparam logic [3:0] OP_DIV      = 4'd3;
    localparam logic [3:0] OP_POWER    = 4'd4;
    localparam logic [3:0] OP_CONJ     = 4'd5;
    localparam logic [3:0] OP_MODULUS  = 4'd6;
    localparam logic [3:0] OP_COMPARE  = 4'd7;
    localparam logic [3:0] OP_CLASSIFY = 4'd8;

    // Fixed point one in Q16.16.
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    // Step counts of the sequenced units.
    localparam logic [3:0] SLOT_COUNT = 4'd8;
    localparam logic [6:0] DIV_STEPS  = 7'd80;
    localparam logic [6:0] SQRT_STEPS = 7'd32;

    // Saturation limits, held at accumulator width.
    localparam logic signed [64:0] SAT_POS = 65'sd2147483647;
    localparam logic signed [64:0] SAT_NEG = -65'sd2147483648;

    // Quadrant codes.
    localparam logic [2:0] QUAD_AXIS = 3'd0;
    localparam logic [2:0] QUAD_ONE  = 3'd1;
    localparam logic [2:0] QUAD_TWO  = 3'd2;
    localparam logic [2:0] QUAD_THR  = 3'd3;
    localparam logic [2:0] QUAD_FOUR = 3'd4;

    // Input transaction.
    typedef struct packed {
        logic [3:0]         opcode;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
        logic [4:0]         exponent;
    } t_cau_in;

    // Result transaction.
    typedef struct packed {
        logic signed [31:0] result_re;
        logic signed [31:0] result_im;
        logic               greater;
        logic               equal;
        logic               less;
        logic               is_real;
        logic               is_zero;
        logic [2:0]         quadrant;
        logic               div_by_zero;
        logic               overflow;
    } t_cau_out;

    // Accumulator that a product slot feeds.
    typedef enum logic [1:0] {
        ACC_NONE = 2'd0,
        ACC_A    = 2'd1,
        ACC_B    = 2'd2,
        ACC_C    = 2'd3
    } t_acc_sel;

    typedef struct packed {
        t_acc_sel sel;
        logic     neg;
    } t_acc_ctl;

    // Sign extension of a 32-bit value to accumulator width.
    function automatic logic signed [64:0] sx65(input logic signed [31:0] v);
        return $signed({{33{v[31]}}, v});
    endfunction

    // Saturate to 32 bits; the top bit of the result is the overflow flag.
    function automatic logic [32:0] sat_wide(input logic signed [64:0] v);
        logic [32:0] r;
        if (v > SAT_POS) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < SAT_NEG) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    // Product slots: 0 xr*yr, 1 xi*yi, 2 xr*yi, 3 xi*yr, 4 yr*yr, 5 yi*yi,
    // 6 xr*xr, 7 xi*xi. This maps each slot to an accumulator per operation.
    function automatic t_acc_ctl slot_map(input logic [3:0] op, input logic [2:0] slot);
        t_acc_ctl c;
        c.sel = ACC_NONE;
        c.neg = 1'b0;
        case (op)
            OP_MUL, OP_POWER: begin
                case (slot)
                    3'd0: c.sel = ACC_A;
                    3'd1: begin c.sel = ACC_A; c.neg = 1'b1; end
                    3'd2: c.sel = ACC_B;
                    3'd3: c.sel = ACC_B;
                    default: c.sel = ACC_NONE;
                endcase
            end
            OP_DIV: begin
                case (slot)
                    3'd0: c.sel = ACC_A;
                    3'd1: c.sel = ACC_A;
                    3'd2: begin c.sel = ACC_B; c.neg = 1'b1; end
                    3'd3: c.sel = ACC_B;
                    3'd4: c.sel = ACC_C;
                    3'd5: c.sel = ACC_C;
                    default: c.sel = ACC_NONE;
                endcase
            end
            OP_MODULUS: begin
                case (slot)
                    3'd6: c.sel = ACC_A;
                    3'd7: c.sel = ACC_A;
                    default: c.sel = ACC_NONE;
                endcase
            end
            OP_COMPARE: begin
                case (slot)
                    3'd4: c.sel = ACC_C;
                    3'd5: c.sel = ACC_C;
                    3'd6: c.sel = ACC_A;
                    3'd7: c.sel = ACC_A;
                    default: c.sel = ACC_NONE;
                endcase
            end
            default: c.sel = ACC_NONE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/complex_arithmetic_unit_top.sv
// Complex Q16.16 arithmetic unit: sequencer, shared multiplier, divider and square root.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_ready    i_in_data  (t_cau_in)
//   result    out        o_out_valid / i_out_ready  o_out_data (t_cau_out)
//
// Add, subtract, conjugate, classify and unused codes go from idle straight to the result.
// Multiply, compare, modulus and divide pass through the multiply phase; power repeats a
// multiply pass per exponent step. The single 32x32 multiplier runs 8 product slots per
// pass, the divider retires one quotient bit per cycle, the square root one bit per cycle.
// One transaction is in flight at a time; a stalled result holds the block until taken.
// Reset (synchronous, active low) returns the sequencer to idle.
`default_nettype none

module complex_arithmetic_unit_top
    import cau_pkg::*;
#(
    parameter int MAX_EXPONENT = MAX_EXPONENT_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_cau_in  i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_cau_out      o_out_data
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_POST = 6'b000100,
        S_DIV  = 6'b001000,
        S_SQRT = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_pvld, n_pvld;

    logic [3:0]         r_op;
    logic signed [31:0] r_xr, r_xi, r_yr, r_yi;
    logic [4:0]         r_steps;
    logic [3:0]         r_slot;
    logic signed [63:0] r_prod;
    t_acc_ctl           r_pctl;
    logic signed [64:0] r_acc_a, r_acc_b, r_acc_c;
    logic               r_ovf;
    t_cau_out           r_out;

    logic [64:0] r_rem;
    logic [63:0] r_num;
    logic [32:0] r_quo;
    logic        r_big, r_dneg, r_dpart;
    logic [6:0]  r_cnt;

    logic [63:0] r_sv, r_sres, r_sone;

    logic               w_accept;
    logic [4:0]         w_steps;
    t_cau_out           w_direct;
    logic signed [31:0] w_mx, w_my;
    logic signed [63:0] w_prod;
    logic signed [64:0] w_addend;
    logic [32:0]        w_sat_a, w_sat_b, w_sat_q, w_sat_s;
    logic [64:0]        w_dtry;
    logic               w_dge;
    logic signed [64:0] w_qsig;
    logic [63:0]        w_ssum;
    logic               w_sge;
    logic [63:0]        w_abs_a, w_abs_b;

    assign w_accept    = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;

    // Power step count, limited by the parameter.
    always_comb begin
        if (int'(i_in_data.exponent) < MAX_EXPONENT) begin
            w_steps = i_in_data.exponent;
        end else begin
            w_steps = 5'(MAX_EXPONENT);
        end
    end

    // Results that need no sequencing.
    always_comb begin
        logic [32:0] s_re;
        logic [32:0] s_im;
        w_direct = '0;
        s_re = '0;
        s_im = '0;
        case (i_in_data.opcode)
            OP_ADD: begin
                s_re = sat_wide(sx65(i_in_data.a_re) + sx65(i_in_data.b_re));
                s_im = sat_wide(sx65(i_in_data.a_im) + sx65(i_in_data.b_im));
                w_direct.result_re = s_re[31:0];
                w_direct.result_im = s_im[31:0];
                w_direct.overflow  = s_re[32] | s_im[32];
            end
            OP_SUB: begin
                s_re = sat_wide(sx65(i_in_data.a_re) - sx65(i_in_data.b_re));
                s_im = sat_wide(sx65(i_in_data.a_im) - sx65(i_in_data.b_im));
                w_direct.result_re = s_re[31:0];
                w_direct.result_im = s_im[31:0];
                w_direct.overflow  = s_re[32] | s_im[32];
            end
            OP_POWER: begin
                w_direct.result_re = Q_ONE;
            end
            OP_CONJ: begin
                s_im = sat_wide(-sx65(i_in_data.a_im));
                w_direct.result_re = i_in_data.a_re;
                w_direct.result_im = s_im[31:0];
                w_direct.overflow  = s_im[32];
            end
            OP_CLASSIFY: begin
                w_direct.is_real = (i_in_data.a_im == 32'sd0);
                w_direct.is_zero = (i_in_data.a_im == 32'sd0) && (i_in_data.a_re == 32'sd0);
                if (i_in_data.a_re > 32'sd0 && i_in_data.a_im > 32'sd0) begin
                    w_direct.quadrant = QUAD_ONE;
                end else if (i_in_data.a_re < 32'sd0 && i_in_data.a_im > 32'sd0) begin
                    w_direct.quadrant = QUAD_TWO;
                end else if (i_in_data.a_re < 32'sd0 && i_in_data.a_im < 32'sd0) begin
                    w_direct.quadrant = QUAD_THR;
                end else if (i_in_data.a_re > 32'sd0 && i_in_data.a_im < 32'sd0) begin
                    w_direct.quadrant = QUAD_FOUR;
                end else begin
                    w_direct.quadrant = QUAD_AXIS;
                end
            end
            default: w_direct = '0;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        case (r_slot[2:0])
            3'd0: begin w_mx = r_xr; w_my = r_yr; end
            3'd1: begin w_mx = r_xi; w_my = r_yi; end
            3'd2: begin w_mx = r_xr; w_my = r_yi; end
            3'd3: begin w_mx = r_xi; w_my = r_yr; end
            3'd4: begin w_mx = r_yr; w_my = r_yr; end
            3'd5: begin w_mx = r_yi; w_my = r_yi; end
            3'd6: begin w_mx = r_xr; w_my = r_xr; end
            3'd7: begin w_mx = r_xi; w_my = r_xi; end
            default: begin w_mx = r_xr; w_my = r_yr; end
        endcase
    end

    assign w_prod   = w_mx * w_my;
    assign w_addend = $signed({r_prod[63], r_prod});

    // Rounding toward minus infinity is the arithmetic shift.
    assign w_sat_a = sat_wide(r_acc_a >>> 16);
    assign w_sat_b = sat_wide(r_acc_b >>> 16);

    // Magnitudes of the division numerators.
    assign w_abs_a = r_acc_a[64] ? 64'(-r_acc_a) : r_acc_a[63:0];
    assign w_abs_b = r_acc_b[64] ? 64'(-r_acc_b) : r_acc_b[63:0];

    // One restoring division step.
    assign w_dtry = {r_rem[63:0], r_num[63]};
    assign w_dge  = (w_dtry >= $unsigned(r_acc_c));
    assign w_qsig = r_dneg ? -$signed({31'd0, r_big, r_quo})
                           :  $signed({31'd0, r_big, r_quo});
    assign w_sat_q = sat_wide(w_qsig);

    // One square root step.
    assign w_ssum  = r_sres + r_sone;
    assign w_sge   = (r_sv >= w_ssum);
    assign w_sat_s = sat_wide($signed({1'b0, r_sres}));

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        n_pvld  = (r_state == S_MUL) && !r_slot[3];
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_data.opcode)
                        OP_MUL, OP_DIV, OP_MODULUS, OP_COMPARE: n_state = S_MUL;
                        OP_POWER: n_state = (w_steps == 5'd0) ? S_OUT : S_MUL;
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_MUL: begin
                if (r_slot == SLOT_COUNT) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                case (r_op)
                    OP_POWER: n_state = (r_steps == 5'd1) ? S_OUT : S_MUL;
                    OP_DIV: n_state = (r_acc_c == 65'sd0) ? S_OUT : S_DIV;
                    OP_MODULUS: n_state = S_SQRT;
                    default: n_state = S_OUT;
                endcase
            end
            S_DIV: begin
                if (r_cnt == DIV_STEPS && r_dpart) begin
                    n_state = S_OUT;
                end
            end
            S_SQRT: begin
                if (r_cnt == SQRT_STEPS) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pvld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pvld  <= n_pvld;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_op    <= i_in_data.opcode;
                    r_ovf   <= 1'b0;
                    r_slot  <= '0;
                    r_acc_a <= '0;
                    r_acc_b <= '0;
                    r_acc_c <= '0;
                    r_steps <= w_steps;
                    r_out   <= w_direct;
                    if (i_in_data.opcode == OP_POWER) begin
                        r_xr <= Q_ONE;
                        r_xi <= 32'sd0;
                        r_yr <= i_in_data.a_re;
                        r_yi <= i_in_data.a_im;
                    end else begin
                        r_xr <= i_in_data.a_re;
                        r_xi <= i_in_data.a_im;
                        r_yr <= i_in_data.b_re;
                        r_yi <= i_in_data.b_im;
                    end
                end
            end
            S_MUL: begin
                // Issue one product per slot, accumulate it in the following cycle.
                if (!r_slot[3]) begin
                    r_prod <= w_prod;
                    r_pctl <= slot_map(r_op, r_slot[2:0]);
                end
                if (r_pvld) begin
                    case (r_pctl.sel)
                        ACC_A: r_acc_a <= r_pctl.neg ? r_acc_a - w_addend : r_acc_a + w_addend;
                        ACC_B: r_acc_b <= r_pctl.neg ? r_acc_b - w_addend : r_acc_b + w_addend;
                        ACC_C: r_acc_c <= r_pctl.neg ? r_acc_c - w_addend : r_acc_c + w_addend;
                        default: r_acc_c <= r_acc_c;
                    endcase
                end
                r_slot <= r_slot + 4'd1;
            end
            S_POST: begin
                case (r_op)
                    OP_MUL: begin
                        r_out.result_re <= w_sat_a[31:0];
                        r_out.result_im <= w_sat_b[31:0];
                        r_out.overflow  <= w_sat_a[32] | w_sat_b[32];
                    end
                    OP_POWER: begin
                        // Feed the rounded step result back as the next multiplicand.
                        r_xr            <= w_sat_a[31:0];
                        r_xi            <= w_sat_b[31:0];
                        r_ovf           <= r_ovf | w_sat_a[32] | w_sat_b[32];
                        r_out.result_re <= w_sat_a[31:0];
                        r_out.result_im <= w_sat_b[31:0];
                        r_out.overflow  <= r_ovf | w_sat_a[32] | w_sat_b[32];
                        r_steps         <= r_steps - 5'd1;
                        r_slot          <= '0;
                        r_acc_a         <= '0;
                        r_acc_b         <= '0;
                        r_acc_c         <= '0;
                    end
                    OP_DIV: begin
                        if (r_acc_c == 65'sd0) begin
                            r_out.div_by_zero <= 1'b1;
                        end else begin
                            r_dneg  <= r_acc_a[64];
                            r_num   <= w_abs_a;
                            r_rem   <= '0;
                            r_quo   <= '0;
                            r_big   <= 1'b0;
                            r_cnt   <= '0;
                            r_dpart <= 1'b0;
                        end
                    end
                    OP_MODULUS: begin
                        r_sv   <= r_acc_a[63:0];
                        r_sres <= '0;
                        r_sone <= 64'h4000_0000_0000_0000;
                        r_cnt  <= '0;
                    end
                    OP_COMPARE: begin
                        r_out.greater <= (r_acc_a > r_acc_c);
                        r_out.equal   <= (r_acc_a == r_acc_c);
                        r_out.less    <= (r_acc_a < r_acc_c);
                    end
                    default: r_ovf <= r_ovf;
                endcase
            end
            S_DIV: begin
                if (r_cnt == DIV_STEPS) begin
                    // Finish one quotient; the real part then starts the imaginary one.
                    if (!r_dpart) begin
                        r_out.result_re <= w_sat_q[31:0];
                        r_ovf   <= w_sat_q[32];
                        r_dneg  <= r_acc_b[64];
                        r_num   <= w_abs_b;
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_big   <= 1'b0;
                        r_cnt   <= '0;
                        r_dpart <= 1'b1;
                    end else begin
                        r_out.result_im <= w_sat_q[31:0];
                        r_out.overflow  <= r_ovf | w_sat_q[32];
                    end
                end else begin
                    r_rem <= w_dge ? (w_dtry - $unsigned(r_acc_c)) : w_dtry;
                    r_quo <= {r_quo[31:0], w_dge};
                    r_big <= r_big | r_quo[32];
                    r_num <= {r_num[62:0], 1'b0};
                    r_cnt <= r_cnt + 7'd1;
                end
            end
            S_SQRT: begin
                if (r_cnt == SQRT_STEPS) begin
                    r_out.result_re <= w_sat_s[31:0];
                    r_out.overflow  <= w_sat_s[32];
                end else begin
                    if (w_sge) begin
                        r_sv   <= r_sv - w_ssum;
                        r_sres <= (r_sres >> 1) + r_sone;
                    end else begin
                        r_sres <= r_sres >> 1;
                    end
                    r_sone <= r_sone >> 2;
                    r_cnt  <= r_cnt + 7'd1;
                end
            end
            default: r_ovf <= r_ovf;
        endcase
    end

    // Input and result sides are never open at the same time.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    // An accepted transaction closes the input side on the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("input still ready after a transaction was taken");

    // A compare gives exactly one of greater, equal and less.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_op == OP_COMPARE) |->
            $onehot({o_out_data.greater, o_out_data.equal, o_out_data.less}))
        else $error("compare flags not one-hot");

    // Division by zero returns zero and never flags overflow.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.div_by_zero) |->
            (o_out_data.result_re == 32'sd0 && o_out_data.result_im == 32'sd0
             && !o_out_data.overflow))
        else $error("division by zero result not cleared");

    // The product pipeline only carries a product while multiplying.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pvld |-> (r_state == S_MUL))
        else $error("product valid outside the multiply phase");

endmodule

`default_nettype wire

// File: verif/cau_result_checker.sv
// Checker for the complex arithmetic unit: predicts each result and compares it on arrival.
`default_nettype none

module cau_result_checker
    import cau_pkg::*;
#(
    parameter int MAX_EXPONENT = MAX_EXPONENT_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_in_ready,
    input  wire t_cau_in  i_in_data,
    input  wire logic     i_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_cau_out i_out_data,
    output int            o_fail_count,
    output int            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        ovf;
    } t_cpx;

    t_cau_out expected_results[$];
    int       fails;

    // Clamp an exact value to Q16.16; the top bit tells whether it was clamped.
    function automatic logic [32:0] clamp_q(input logic signed [127:0] v);
        if (v > 128'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (v < -128'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

    // Complex product with floor rounding of the Q16.16 shift.
    function automatic t_cpx cplx_mul(input logic signed [31:0] xr, input logic signed [31:0] xi,
                                      input logic signed [31:0] yr, input logic signed [31:0] yi);
        logic signed [127:0] ar, ai, br, bi, pr, pi;
        logic [32:0]         cr, ci;
        t_cpx                r;
        ar = xr; ai = xi; br = yr; bi = yi;
        pr = (ar * br - ai * bi) >>> 16;
        pi = (ar * bi + ai * br) >>> 16;
        cr = clamp_q(pr);
        ci = clamp_q(pi);
        r.re = cr[31:0];
        r.im = ci[31:0];
        r.ovf = cr[32] | ci[32];
        return r;
    endfunction

    // Quotient num * 2^16 / den, truncated toward zero.
    function automatic logic signed [127:0] trunc_quot(input logic signed [127:0] num,
                                                       input logic [127:0] den);
        logic [127:0] m, q;
        m = (num < 0) ? -num : num;
        q = (m << 16) / den;
        return (num < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [127:0] int_sqrt(input logic [127:0] v);
        logic [127:0] res, one;
        res = 0;
        one = 128'd1 << 62;
        while (one > v) one = one >> 2;
        while (one != 0) begin
            if (v >= res + one) begin
                v = v - (res + one);
                res = (res >> 1) + one;
            end else begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        return res;
    endfunction

    // Expected result of one input transaction.
    function automatic t_cau_out predict_result(input t_cau_in t);
        t_cau_out            o;
        logic signed [127:0] ar, ai, br, bi, ma, mb;
        logic [32:0]         cr, ci;
        t_cpx                acc;
        int                  steps;
        o = '0;
        ar = t.a_re; ai = t.a_im; br = t.b_re; bi = t.b_im;
        ma = ar * ar + ai * ai;
        mb = br * br + bi * bi;
        cr = '0;
        ci = '0;
        case (t.opcode)
            OP_ADD: begin
                cr = clamp_q(ar + br);
                ci = clamp_q(ai + bi);
            end
            OP_SUB: begin
                cr = clamp_q(ar - br);
                ci = clamp_q(ai - bi);
            end
            OP_MUL: begin
                acc = cplx_mul(t.a_re, t.a_im, t.b_re, t.b_im);
                cr = {acc.ovf, acc.re};
                ci = {1'b0, acc.im};
            end
            OP_DIV: begin
                if (mb == 0) begin
                    o.div_by_zero = 1'b1;
                end else begin
                    cr = clamp_q(trunc_quot(ar * br + ai * bi, mb));
                    ci = clamp_q(trunc_quot(ai * br - ar * bi, mb));
                end
            end
            OP_POWER: begin
                steps = (t.exponent < MAX_EXPONENT) ? t.exponent : MAX_EXPONENT;
                acc.re = Q_ONE;
                acc.im = '0;
                acc.ovf = 1'b0;
                for (int k = 0; k < steps; k++) begin
                    logic sticky;
                    sticky = acc.ovf;
                    acc = cplx_mul(acc.re, acc.im, t.a_re, t.a_im);
                    acc.ovf = acc.ovf | sticky;
                end
                cr = {acc.ovf, acc.re};
                ci = {1'b0, acc.im};
            end
            OP_CONJ: begin
                cr = {1'b0, t.a_re};
                ci = clamp_q(-ai);
            end
            OP_MODULUS: begin
                cr = clamp_q($signed(int_sqrt(ma)));
            end
            OP_COMPARE: begin
                o.greater = ma > mb;
                o.equal = ma == mb;
                o.less = ma < mb;
            end
            OP_CLASSIFY: begin
                o.is_real = ai == 0;
                o.is_zero = (ar == 0) && (ai == 0);
                if (ar > 0 && ai > 0) o.quadrant = QUAD_ONE;
                else if (ar < 0 && ai > 0) o.quadrant = QUAD_TWO;
                else if (ar < 0 && ai < 0) o.quadrant = QUAD_THR;
                else if (ar > 0 && ai < 0) o.quadrant = QUAD_FOUR;
                else o.quadrant = QUAD_AXIS;
            end
            default: ;
        endcase
        o.result_re = cr[31:0];
        o.result_im = ci[31:0];
        o.overflow = cr[32] | ci[32];
        return o;
    endfunction

    // Predict on each accepted input and compare on each accepted result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_results.delete();
            fails <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(predict_result(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result transaction %h", $realtime, i_out_data);
                    fails <= fails + 1;
                end else begin
                    t_cau_out e;
                    e = expected_results.pop_front();
                    if (e.result_re !== i_out_data.result_re || e.result_im !== i_out_data.result_im
                        || e.greater !== i_out_data.greater || e.equal !== i_out_data.equal
                        || e.less !== i_out_data.less || e.is_real !== i_out_data.is_real
                        || e.is_zero !== i_out_data.is_zero
                        || e.quadrant !== i_out_data.quadrant
                        || e.div_by_zero !== i_out_data.div_by_zero
                        || e.overflow !== i_out_data.overflow) begin
                        $display("%0t: mismatch: expected %h actual %h", $realtime, e, i_out_data);
                        fails <= fails + 1;
                    end
                end
            end
        end
    end

    assign o_fail_count = fails;
    assign o_pending = expected_results.size();

endmodule

`default_nettype wire

// File: verif/tb_complex_arithmetic_unit_top.sv
// Testbench top for the complex arithmetic unit: stimulus, flow control and verdict.
`default_nettype none

module tb_complex_arithmetic_unit_top;
    import cau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1030;
    localparam int CYCLE_LIMIT = 3000000;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_ready;
    t_cau_in  i_in_data = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_cau_out o_out_data;
    int       fail_count;
    int       pending;
    int       cycles = 0;
    int       send_idle_pct = 12;
    int       recv_stall_pct = 71;

    complex_arithmetic_unit_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    cau_result_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out_data(o_out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    // Receiver stalls at random; cycle limit guards against a hang.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one transaction after optional idle cycles and wait until it is taken.
    task automatic send_op(input logic [3:0] op, input logic [31:0] ar, input logic [31:0] ai,
                           input logic [31:0] br, input logic [31:0] bi, input logic [4:0] ex);
        t_cau_in t;
        t.opcode = op;
        t.a_re = ar;
        t.a_im = ai;
        t.b_re = br;
        t.b_im = bi;
        t.exponent = ex;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= t;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Operand part: full range, within 4 LSBs of zero, within +/-4.0 in Q16.16, or an extreme.
    function automatic logic [31:0] rand_part();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom();
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            5: return 32'h0;
            6: return 32'($signed($urandom_range(0, 8)) - 4);
            default: return 32'($signed($urandom_range(0, 524288)) - 262144);
        endcase
    endfunction

    initial begin
        logic [3:0]  op;
        logic [31:0] br, bi;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed cases: extremes, every operation and the special cases.
        send_op(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 5'd0);
        send_op(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 5'd0);
        send_op(OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 32'h0001_8000, 5'd0);
        send_op(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 5'd0);
        send_op(OP_MUL, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0, 5'd0);
        send_op(OP_DIV, 32'h0005_0000, 32'h0001_0000, 32'h0, 32'h0, 5'd0);
        send_op(OP_DIV, 32'h0005_0000, 32'hFFFE_0000, 32'h0001_0000, 32'h0002_0000, 5'd0);
        send_op(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 5'd0);
        send_op(OP_DIV, 32'hFFFF_FFFF, 32'h0, 32'h0003_0000, 32'h0, 5'd0);
        send_op(OP_POWER, 32'h0001_2000, 32'h0000_8000, 32'h0, 32'h0, 5'd0);
        send_op(OP_POWER, 32'h0000_F000, 32'h0000_4000, 32'h0, 32'h0, 5'd31);
        send_op(OP_POWER, 32'h0002_0000, 32'h0001_0000, 32'h0, 32'h0, 5'd31);
        send_op(OP_CONJ, 32'h1234_5678, 32'h8000_0000, 32'h0, 32'h0, 5'd0);
        send_op(OP_CONJ, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 5'd0);
        send_op(OP_MODULUS, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 5'd0);
        send_op(OP_MODULUS, 32'h0003_0000, 32'hFFFC_0000, 32'h0, 32'h0, 5'd0);
        send_op(OP_COMPARE, 32'h0003_0000, 32'h0004_0000, 32'hFFFB_0000, 32'h0, 5'd0);
        send_op(OP_COMPARE, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd0);
        send_op(OP_COMPARE, 32'h1, 32'h0, 32'h0, 32'h2, 5'd0);
        send_op(OP_CLASSIFY, 32'h0, 32'h0, 32'h0, 32'h0, 5'd0);
        send_op(OP_CLASSIFY, 32'h1, 32'h1, 32'h0, 32'h0, 5'd0);
        send_op(OP_CLASSIFY, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 5'd0);
        send_op(OP_CLASSIFY, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 5'd0);
        send_op(OP_CLASSIFY, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 5'd0);
        send_op(4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);

        // Random part in three flow-control phases.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                send_idle_pct = 71;
                recv_stall_pct = 12;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(0, 8));
            br = rand_part();
            bi = rand_part();
            if ($urandom_range(0, 7) == 0) begin
                br = '0;
                bi = '0;
            end
            send_op(op, rand_part(), rand_part(), br, bi, 5'($urandom()));
        end
        i_in_valid <= 1'b0;

        // Drain, then allow the longest operation to pass.
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
